>>> hw/rtl/fltl_pkg.sv
// ----------------------------------------------------------------------------
// fltl_pkg
// shared constants and types for the fault latch with timeouts
// ----------------------------------------------------------------------------
`default_nettype none

package fltl_pkg;

  localparam int unsigned FAULT_COUNT_DEF = 16;
  localparam int unsigned MAX_SOURCES     = 32;
  localparam int unsigned FLAG_W          = 16;
  localparam int unsigned TICK_W          = 16;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 3;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 16'd5000;
  localparam logic [FLAG_W-1:0] CRITICAL_RESET = 16'd31;

  // register index, taken from paddr[2]
  localparam logic REG_CRITICAL_MASK = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_TRIGGER = 1'b1;

  // status rippled along the row of cells
  typedef struct packed {
    logic expired;    // some countdown ran out on this tick
    logic critical;   // some critical flag is latched after this step
    logic trig_crit;  // the triggered source is critical
  } fltl_chain_t;

  typedef struct packed {
    logic [FLAG_W-1:0] active_faults;
    logic              faulted_mode;
    logic              critical_present;
  } fltl_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/fltl_cell.sv
// ----------------------------------------------------------------------------
// fltl_cell
// one fault source: countdown, latched flag and chain status
// ----------------------------------------------------------------------------
`default_nettype none

module fltl_cell import fltl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tick_i,
  input  wire logic              trig_i,
  input  wire logic [TICK_W-1:0] timeout_i,
  input  wire logic              crit_i,
  input  wire fltl_chain_t       chain_i,
  output fltl_chain_t            chain_o,
  output logic                   flag_o
);

  logic [TICK_W-1:0] count_q, count_d;
  logic              expire;

  // the flag is latched exactly while the countdown runs
  always_comb begin
    count_d = count_q;
    expire  = 1'b0;
    if (trig_i) begin
      count_d = timeout_i;
    end else if (tick_i && (count_q != '0)) begin
      count_d = count_q - TICK_W'(1);
      expire  = (count_q == TICK_W'(1));
    end
  end

  assign flag_o = (count_d != '0);

  assign chain_o.expired   = chain_i.expired | expire;
  assign chain_o.critical  = chain_i.critical | (flag_o & crit_i);
  assign chain_o.trig_crit = chain_i.trig_crit | (trig_i & crit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fltl_out_buf.sv
// ----------------------------------------------------------------------------
// fltl_out_buf
// output register with a skid stage
// ----------------------------------------------------------------------------
`default_nettype none

module fltl_out_buf import fltl_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire fltl_result_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output fltl_result_t      out_data_o
);

  logic         out_valid_q, skid_valid_q;
  fltl_result_t out_q, skid_q;
  logic         accept, out_free;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= accept;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (accept) begin
          skid_q <= in_data_i;
        end
      end else if (accept) begin
        out_q <= in_data_i;
      end
    end else if (accept) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/fault_latch_with_timeouts.sv
// ----------------------------------------------------------------------------
// fault_latch_with_timeouts
// latched fault flags with per-source countdowns and a faulted mode
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries command_i and
//   fault_index_i; a tick counts every running countdown down by one, a
//   trigger latches a source and restarts its countdown at timeout_ticks.
//   output channel (out_valid_o / out_stall_i) returns one transaction per
//   input transaction: active_faults_o, faulted_mode_o, critical_present_o.
//   results are registered; one item is taken every cycle while in_stall_o is
//   low, the row of cells updates all countdowns in the same cycle.
//   the output register plus a skid stage hold up to two results, so a
//   stalled receiver is absorbed for one more transaction before in_stall_o
//   rises; in_stall_o is a registered signal.
//   reset clears all flags and countdowns, leaves the unit in ready mode and
//   loads critical_mask = 31 and timeout_ticks = 5000.
//   registers sit on the apb port at byte 0 (critical_mask) and byte 4
//   (timeout_ticks); write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_latch_with_timeouts import fltl_pkg::*; #(
  parameter int unsigned FAULT_COUNT = FAULT_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // apb configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  command_i,
  input  wire logic [3:0]            fault_index_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [FLAG_W-1:0]          active_faults_o,
  output logic                       faulted_mode_o,
  output logic                       critical_present_o
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [FLAG_W-1:0] crit_mask_q;
  logic [TICK_W-1:0] timeout_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_mask_q <= CRITICAL_RESET;
      timeout_q   <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CRITICAL_MASK: crit_mask_q <= pwdata[FLAG_W-1:0];
        REG_TIMEOUT_TICKS: timeout_q   <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CRITICAL_MASK: prdata = APB_DATA_W'(crit_mask_q);
      REG_TIMEOUT_TICKS: prdata = APB_DATA_W'(timeout_q);
      default:           prdata = '0;
    endcase
  end

  // a zero timeout behaves as one tick
  logic [TICK_W-1:0] timeout_eff;
  assign timeout_eff = (timeout_q == '0) ? TICK_W'(1) : timeout_q;

  // ---------------------------------------------------------------------------
  // input acceptance
  // ---------------------------------------------------------------------------
  logic accept, tick, trig_any;

  assign accept   = in_valid_i & ~in_stall_o;
  assign tick     = accept & (command_i == CMD_TICK);
  assign trig_any = accept & (command_i == CMD_TRIGGER);

  // ---------------------------------------------------------------------------
  // row of cells, status ripples from cell 0 upward
  // ---------------------------------------------------------------------------
  fltl_chain_t             chain [FAULT_COUNT+1];
  logic [FAULT_COUNT-1:0]  flags;

  assign chain[0] = '0;

  for (genvar g = 0; g < FAULT_COUNT; g++) begin : g_cell
    logic hit, crit;
    // fault_index is four bits wide, so sources above 15 never trigger
    if (g < FLAG_W) begin : g_low
      assign hit  = trig_any & (fault_index_i == 4'(g));
      assign crit = crit_mask_q[g];
    end else begin : g_high
      assign hit  = 1'b0;
      assign crit = 1'b0;
    end

    fltl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tick_i    (tick),
      .trig_i    (hit),
      .timeout_i (timeout_eff),
      .crit_i    (crit),
      .chain_i   (chain[g]),
      .chain_o   (chain[g+1]),
      .flag_o    (flags[g])
    );
  end

  // ---------------------------------------------------------------------------
  // faulted mode
  // ---------------------------------------------------------------------------
  // a critical trigger enters the faulted mode; recovery is checked only on
  // a tick that let some countdown expire and left no critical flag
  logic        mode_q, mode_d;
  fltl_chain_t row;

  assign row = chain[FAULT_COUNT];

  always_comb begin
    mode_d = mode_q;
    if (trig_any && row.trig_crit) begin
      mode_d = 1'b1;
    end else if (tick && row.expired && !row.critical) begin
      mode_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result assembly and output buffering
  // ---------------------------------------------------------------------------
  fltl_result_t res, out_res;

  for (genvar b = 0; b < FLAG_W; b++) begin : g_act
    if (b < FAULT_COUNT) begin : g_used
      assign res.active_faults[b] = flags[b];
    end else begin : g_none
      assign res.active_faults[b] = 1'b0;
    end
  end

  assign res.faulted_mode     = mode_d;
  assign res.critical_present = row.critical;

  fltl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign active_faults_o    = out_res.active_faults;
  assign faulted_mode_o     = out_res.faulted_mode;
  assign critical_present_o = out_res.critical_present;

endmodule

`default_nettype wire
